// ===== rtl/core/hbs_pkg.sv =====
package hbs_pkg;

	localparam int MAX_GRID_COLUMNS = 256;
	localparam int MAX_GRID_ROWS    = 256;
	localparam int HEIGHT_BITS      = 16;

	localparam int COL_BITS  = $clog2(MAX_GRID_COLUMNS);
	localparam int ROW_BITS  = $clog2(MAX_GRID_ROWS);
	localparam int BANK_DEPTH = (MAX_GRID_COLUMNS / 2) * (MAX_GRID_ROWS / 2);
	localparam int BANK_AW   = $clog2(BANK_DEPTH);

	localparam int GRID_W = 9;
	localparam int EXT_W  = 13;
	localparam int POS_W  = 20;
	localparam int SUM_W  = 22;
	localparam int NUM_W  = 31;
	localparam int REM_W  = 30;
	localparam int Q_W    = 17;
	localparam int NDIV   = Q_W;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORLD_EXTENT_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WORLD_EXTENT_Z = 3'd3;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// first member sits in the high bits: matches tdata with col in [7:0]
	typedef struct packed {
		logic [15:0] height;
		logic [7:0]  row;
		logic [7:0]  col;
	} wr_t;

	typedef struct packed {
		logic             neg;
		logic             sat;
		logic [Q_W-1:0]   q;
		logic [REM_W-1:0] rem;
	} axis_t;

	typedef struct packed {
		logic [7:0] c;
		logic [7:0] o;
		logic [7:0] f;
		logic       in_grid;
	} coord_t;

	function automatic axis_t div_init(logic signed [NUM_W-1:0] num, logic [EXT_W-1:0] e);
		axis_t r;
		r.neg = num[NUM_W-1];
		r.rem = num[REM_W-1:0];
		r.q   = '0;
		r.sat = !r.neg && ({1'b0, r.rem} >= (NUM_W'(e) << Q_W));
		return r;
	endfunction

	function automatic axis_t div_step(axis_t a, logic [EXT_W-1:0] e, logic [4:0] sh);
		axis_t r;
		logic [REM_W-1:0] d;
		r = a;
		d = REM_W'(e) << sh;
		if (!a.neg && !a.sat && a.rem >= d) begin
			r.rem   = a.rem - d;
			r.q[sh] = 1'b1;
		end
		return r;
	endfunction

	function automatic coord_t axis_post(axis_t a, logic [7:0] gm1);
		coord_t r;
		logic [Q_W-1:0] lim;
		lim = {1'b0, gm1, 8'd0};
		r.in_grid = !a.neg && !a.sat && ((a.q < lim) || (a.q == lim && a.rem == '0));
		if (a.neg) begin
			r.c = '0;
			r.f = '0;
		end else if (a.sat || a.q[Q_W-1:8] > {1'b0, gm1}) begin
			r.c = gm1;
			r.f = '0;
		end else begin
			r.c = a.q[15:8];
			r.f = a.q[7:0];
		end
		r.o = (r.c < gm1) ? r.c + 8'd1 : r.c;
		return r;
	endfunction

endpackage

// ===== rtl/core/hbs_ram.sv =====
module hbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/heightmap_bilinear_sampler_core.sv =====
// Heightmap bilinear sampler.
// Input stream s_*: s_tuser is the command (0 writes one height cell, 1 samples).
// A write stores cell_height at (cell_row, cell_col); it gives no result.
// A sample maps world (pos_x, pos_z) to grid coordinates, reads the four
// neighbouring heights and returns the blended height and an inside flag on m_*.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; write it only
// while no transaction is in flight.
// Throughput: one transaction per cycle while m_* is not stalled. The 17 stage
// restoring divider (one quotient bit per stage per axis) sets the depth; four
// height banks split by row and column parity serve the four neighbour reads in
// the same cycle.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready is low,
// so s_tready follows that; bubbles inside the pipeline hold as well.
// Reset clears all valid bits and loads the registers with 256 columns, 256 rows
// and world extents of 256. Heights are not cleared: read only written cells.
module heightmap_bilinear_sampler_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [71:0]                        s_tdata,  // cell_col, cell_row, cell_height, pos_x, pos_z
	input  logic                               s_tuser,  // command
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,  // sampled_height, inside_res, zero pad
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [12:0]                        cfg_data
);

	logic [hbs_pkg::GRID_W-1:0] grid_columns_q, grid_rows_q;
	logic [hbs_pkg::EXT_W-1:0]  world_extent_x_q, world_extent_z_q;

	logic [hbs_pkg::EXT_W-1:0]  ext_e [2];
	logic [hbs_pkg::GRID_W-1:0] grid_g [2];
	logic [7:0]                 gm1 [2];
	logic [hbs_pkg::GRID_W-1:0] grid_raw [2];
	logic [hbs_pkg::EXT_W-1:0]  ext_raw [2];
	logic signed [hbs_pkg::POS_W-1:0] pos_in [2];

	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q   <= 9'd256;
			grid_rows_q      <= 9'd256;
			world_extent_x_q <= 13'd256;
			world_extent_z_q <= 13'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				hbs_pkg::CFG_GRID_COLUMNS:   grid_columns_q   <= cfg_data[8:0];
				hbs_pkg::CFG_GRID_ROWS:      grid_rows_q      <= cfg_data[8:0];
				hbs_pkg::CFG_WORLD_EXTENT_X: world_extent_x_q <= cfg_data;
				hbs_pkg::CFG_WORLD_EXTENT_Z: world_extent_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign grid_raw[0] = grid_columns_q;
	assign grid_raw[1] = grid_rows_q;
	assign ext_raw[0]  = world_extent_x_q;
	assign ext_raw[1]  = world_extent_z_q;
	assign pos_in[0]   = s_tdata[51:32];
	assign pos_in[1]   = s_tdata[71:52];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			ext_e[k] = (ext_raw[k] == '0) ? 13'd1 : ext_raw[k];
			if (grid_raw[k] == '0)
				grid_g[k] = 9'd1;
			else if (grid_raw[k] > 9'd256)
				grid_g[k] = 9'd256;
			else
				grid_g[k] = grid_raw[k];
			gm1[k] = 8'(grid_g[k] - 9'd1);
		end
	end

	// stage 1: offset by half extent
	logic        v_s1, cmd_s1;
	hbs_pkg::wr_t wr_s1;
	logic signed [hbs_pkg::SUM_W-1:0] a_s1 [2];

	// stage 2: scale by grid size
	logic        v_s2, cmd_s2;
	hbs_pkg::wr_t wr_s2;
	logic signed [hbs_pkg::NUM_W-1:0] num_s2 [2];

	// divider stages
	logic          v_sd   [hbs_pkg::NDIV];
	logic          cmd_sd [hbs_pkg::NDIV];
	hbs_pkg::wr_t  wr_sd  [hbs_pkg::NDIV];
	hbs_pkg::axis_t ax_sd [hbs_pkg::NDIV][2];

	// stage 3: cell, fraction, neighbour
	logic          v_s3, cmd_s3;
	hbs_pkg::wr_t  wr_s3;
	hbs_pkg::coord_t co_s3 [2];

	// stage 4: bank read data
	logic       v_s4, cmd_s4, inside_s4;
	logic [7:0] fx_s4, fz_s4;
	logic       cx0_s4, ox0_s4, cz0_s4, oz0_s4;
	logic [15:0] rd [4];

	// stage 5: row blends
	logic       v_s5, inside_s5;
	logic [7:0] fz_s5;
	logic signed [25:0] top_s5, bot_s5;

	// stage 6: output register
	logic        v_s6, inside_s6;
	logic [15:0] res_s6;

	assign en       = !v_s6 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int j = 0; j < hbs_pkg::NDIV; j++) v_sd[j] <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_sd[0] <= v_s2;
			for (int j = 1; j < hbs_pkg::NDIV; j++) v_sd[j] <= v_sd[j-1];
			v_s3 <= v_sd[hbs_pkg::NDIV-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4 && (cmd_s4 == hbs_pkg::CMD_SAMPLE);
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= s_tuser;
			wr_s1  <= s_tdata[31:0];
			for (int k = 0; k < 2; k++) begin
				a_s1[k] <= hbs_pkg::SUM_W'(pos_in[k])
					+ $signed({2'b00, ext_e[k], 7'd0});
			end
			cmd_s2 <= cmd_s1;
			wr_s2  <= wr_s1;
			for (int k = 0; k < 2; k++) begin
				num_s2[k] <= hbs_pkg::NUM_W'(a_s1[k] * $signed({1'b0, grid_g[k]}));
			end
			cmd_sd[0] <= cmd_s2;
			wr_sd[0]  <= wr_s2;
			for (int j = 1; j < hbs_pkg::NDIV; j++) begin
				cmd_sd[j] <= cmd_sd[j-1];
				wr_sd[j]  <= wr_sd[j-1];
			end
			cmd_s3 <= cmd_sd[hbs_pkg::NDIV-1];
			wr_s3  <= wr_sd[hbs_pkg::NDIV-1];
			for (int k = 0; k < 2; k++) begin
				co_s3[k] <= hbs_pkg::axis_post(ax_sd[hbs_pkg::NDIV-1][k], gm1[k]);
			end
			cmd_s4    <= cmd_s3;
			inside_s4 <= co_s3[0].in_grid && co_s3[1].in_grid;
			fx_s4     <= co_s3[0].f;
			fz_s4     <= co_s3[1].f;
			cx0_s4    <= co_s3[0].c[0];
			ox0_s4    <= co_s3[0].o[0];
			cz0_s4    <= co_s3[1].c[0];
			oz0_s4    <= co_s3[1].o[0];
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < hbs_pkg::NDIV; j++) begin : g_div
		for (genvar k = 0; k < 2; k++) begin : g_axis
			always_ff @(posedge clk) begin
				if (en) begin
					if (j == 0)
						ax_sd[j][k] <= hbs_pkg::div_step(
							hbs_pkg::div_init(num_s2[k], ext_e[k]), ext_e[k],
							5'(hbs_pkg::Q_W - 1 - j));
					else
						ax_sd[j][k] <= hbs_pkg::div_step(ax_sd[(j == 0) ? 0 : j-1][k],
							ext_e[k], 5'(hbs_pkg::Q_W - 1 - j));
				end
			end
		end
	end

	// bank b holds cells with row parity b[1] and column parity b[0]
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0] rcol, rrow;
		logic       we;
		assign rcol = (co_s3[0].c[0] == b[0]) ? co_s3[0].c : co_s3[0].o;
		assign rrow = (co_s3[1].c[0] == b[1]) ? co_s3[1].c : co_s3[1].o;
		assign we = en && v_s3 && (cmd_s3 == hbs_pkg::CMD_WRITE)
			&& (wr_s3.col[0] == b[0]) && (wr_s3.row[0] == b[1]);
		hbs_ram #(
			.WIDTH (hbs_pkg::HEIGHT_BITS),
			.DEPTH (hbs_pkg::BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr ({wr_s3.row[7:1], wr_s3.col[7:1]}),
			.wdata (wr_s3.height),
			.re    (en),
			.raddr ({rrow[7:1], rcol[7:1]}),
			.rdata (rd[b])
		);
	end

	logic signed [15:0] h_cc, h_oc, h_co, h_oo;
	logic signed [9:0]  wx0, wx1, wz0, wz1;
	logic signed [35:0] acc;

	always_comb begin
		h_cc = rd[{cz0_s4, cx0_s4}];
		h_oc = rd[{cz0_s4, ox0_s4}];
		h_co = rd[{oz0_s4, cx0_s4}];
		h_oo = rd[{oz0_s4, ox0_s4}];
		wx0  = $signed(10'd256 - {2'b00, fx_s4});
		wx1  = $signed({2'b00, fx_s4});
		wz0  = $signed(10'd256 - {2'b00, fz_s5});
		wz1  = $signed({2'b00, fz_s5});
		acc  = top_s5 * wz0 + bot_s5 * wz1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s5 <= inside_s4;
			fz_s5     <= fz_s4;
			top_s5    <= 26'(h_cc * wx0 + h_oc * wx1);
			bot_s5    <= 26'(h_co * wx0 + h_oo * wx1);
			inside_s6 <= inside_s5;
			res_s6    <= acc[31:16];
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = {7'd0, inside_s6, res_s6};

	ap_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	ap_no_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && (cmd_s4 == hbs_pkg::CMD_WRITE) && en |=> !v_s5)
		else $error("write transaction produced a result");

	ap_cell_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (cmd_s3 == hbs_pkg::CMD_SAMPLE) |->
		co_s3[0].c <= gm1[0] && co_s3[0].o <= gm1[0]
		&& co_s3[1].c <= gm1[1] && co_s3[1].o <= gm1[1])
		else $error("neighbour cell outside grid");

	ap_neighbour: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (cmd_s3 == hbs_pkg::CMD_SAMPLE) |->
		(co_s3[0].o == co_s3[0].c || co_s3[0].o == co_s3[0].c + 8'd1)
		&& (co_s3[1].o == co_s3[1].c || co_s3[1].o == co_s3[1].c + 8'd1))
		else $error("upper neighbour not adjacent");

	ap_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s3) && $stable(co_s3[0]) && $stable(co_s3[1]))
		else $error("pipeline moved during stall");

endmodule
